// ===== design/table_driven_dfa_recognizer_unit_assert.svh =====
// Assertion shorthands shared by the recognizer modules.
// Each expects clk and rst in scope.
`ifndef TABLE_DRIVEN_DFA_RECOGNIZER_UNIT_ASSERT_SVH
`define TABLE_DRIVEN_DFA_RECOGNIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define TDFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tdfa_pkg.sv =====
package tdfa_pkg;

  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 8;
  localparam int STATE_W     = 4;
  localparam int IDX_W       = 3;
  localparam int ADDR_W      = STATE_W + IDX_W;
  localparam int DEPTH       = NUM_STATES * NUM_SYMBOLS;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 4;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // queue depth, power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [KIND_W-1:0] KIND_STEP    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDEF   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CHARS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LEN   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic [STATE_W-1:0] from_state;
    logic [IDX_W-1:0]   symbol_index;
    logic [STATE_W-1:0] target_state;
    logic               entry_defined;
  } item_t;

  typedef struct packed {
    logic [NUM_SYMBOLS*CHAR_W-1:0] chars;
    logic [LEN_W-1:0]              len;
  } alpha_cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0]    start_state;
    logic [NUM_STATES-1:0] accept_mask;
  } back_cfg_t;

endpackage

// ===== design/table_driven_dfa_recognizer_unit.sv =====
// Programmable DFA recogniser. Configure the start state, accepting set and
// alphabet (at most eight characters) through the write port while idle, fill
// the 16 x 8 transition table with write items, then stream symbol items; each
// item gives exactly one result beat with the state after it, its accepting bit
// and a status (ok, symbol not in alphabet, transition undefined; on an error
// the state holds). The transition table reads as all undefined straight after
// reset, with no clearing pass. The input side takes one beat a cycle, while
// the two-entry queue has room; the back end retires a write, restart or
// unknown symbol straight from idle and a table step through a look state on
// the registered table read, which the next step's address depends on.
module table_driven_dfa_recognizer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tdfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdfa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tdfa_pkg::KIND_W-1:0]       kind,
  input  logic [tdfa_pkg::CHAR_W-1:0]       symbol,
  input  logic [tdfa_pkg::STATE_W-1:0]      from_state,
  input  logic [tdfa_pkg::IDX_W-1:0]        symbol_index,
  input  logic [tdfa_pkg::STATE_W-1:0]      target_state,
  input  logic                              entry_defined,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tdfa_pkg::STATE_W-1:0]      current_state_out,
  output logic                              accepted,
  output logic [tdfa_pkg::STATUS_W-1:0]     status
);
  import tdfa_pkg::*;

  alpha_cfg_t alpha;
  back_cfg_t  bcfg;
  logic       q_full;
  logic       q_push;
  item_t      q_item;
  logic       q_pop;
  logic       q_valid;
  item_t      q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      bcfg.start_state <= '0;
      bcfg.accept_mask <= '0;
      alpha.chars      <= '0;
      alpha.len        <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_STATE: bcfg.start_state <= cfg_data[STATE_W-1:0];
        REG_ACCEPT_MASK: bcfg.accept_mask <= cfg_data[NUM_STATES-1:0];
        REG_ALPHA_CHARS: alpha.chars      <= cfg_data[NUM_SYMBOLS*CHAR_W-1:0];
        REG_ALPHA_LEN:   alpha.len        <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tdfa_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .symbol        (symbol),
    .from_state    (from_state),
    .symbol_index  (symbol_index),
    .target_state  (target_state),
    .entry_defined (entry_defined),
    .alpha         (alpha),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_item)
  );

  tdfa_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  tdfa_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (bcfg),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .current_state_out (current_state_out),
    .accepted          (accepted),
    .status            (status)
  );

endmodule

// ===== design/tdfa_front.sv =====
module tdfa_front (
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tdfa_pkg::KIND_W-1:0]       kind,
  input  logic [tdfa_pkg::CHAR_W-1:0]       symbol,
  input  logic [tdfa_pkg::STATE_W-1:0]      from_state,
  input  logic [tdfa_pkg::IDX_W-1:0]        symbol_index,
  input  logic [tdfa_pkg::STATE_W-1:0]      target_state,
  input  logic                              entry_defined,
  input  tdfa_pkg::alpha_cfg_t              alpha,
  input  logic                              q_full,
  output logic                              q_push,
  output tdfa_pkg::item_t                   q_item
);
  import tdfa_pkg::*;

  logic             hit;
  logic [IDX_W-1:0] idx;

  // lowest matching index wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
      if (int'(alpha.len) > i && alpha.chars[i*CHAR_W +: CHAR_W] == symbol) begin
        hit = 1'b1;
        idx = IDX_W'(i);
      end
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.kind          = kind;
    q_item.hit           = hit;
    q_item.idx           = idx;
    q_item.from_state    = from_state;
    q_item.symbol_index  = symbol_index;
    q_item.target_state  = target_state;
    q_item.entry_defined = entry_defined;
  end

endmodule

// ===== design/tdfa_fifo.sv =====
`include "table_driven_dfa_recognizer_unit_assert.svh"

module tdfa_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tdfa_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tdfa_pkg::item_t head
);
  import tdfa_pkg::*;

  item_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_CNT_W-1:0] count;

  assign full       = count == Q_CNT_W'(Q_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  `TDFA_ASSERT_IMPL(a_pop_nonempty, pop, head_valid, "queue popped while empty")
  `TDFA_ASSERT_IMPL(a_push_room, push, !full, "queue pushed while full")
  `TDFA_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count lost a beat")

endmodule

// ===== design/tdfa_back.sv =====
`include "table_driven_dfa_recognizer_unit_assert.svh"

module tdfa_back (
  input  logic                            clk,
  input  logic                            rst,
  input  tdfa_pkg::back_cfg_t             cfg,
  input  logic                            q_valid,
  input  tdfa_pkg::item_t                 q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tdfa_pkg::STATE_W-1:0]    current_state_out,
  output logic                            accepted,
  output logic [tdfa_pkg::STATUS_W-1:0]   status
);
  import tdfa_pkg::*;

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t             state;
  logic [STATE_W-1:0] cur_state;
  logic [DEPTH-1:0]   vld;

  logic [STATE_W:0]   table_mem [DEPTH];
  logic [STATE_W:0]   rd_entry;
  logic               rd_vld;
  logic               rd_def;

  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic               do_write;
  logic               do_look;

  assign q_pop    = state == S_IDLE && q_valid && (!out_valid || out_ready);
  assign waddr    = {q_head.from_state, q_head.symbol_index};
  assign raddr    = {cur_state, q_head.idx};
  assign do_write = q_pop && q_head.kind == KIND_WRITE;
  assign do_look  = q_pop && q_head.kind == KIND_STEP && q_head.hit;
  assign rd_def   = rd_vld && rd_entry[STATE_W];

  always_ff @(posedge clk) begin
    if (do_write) begin
      table_mem[waddr] <= {q_head.entry_defined, q_head.target_state};
    end
    if (do_look) begin
      rd_entry <= table_mem[raddr];
      rd_vld   <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_state <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_head.kind)
              KIND_STEP: begin
                if (q_head.hit) begin
                  out_valid <= 1'b0;
                  state     <= S_LOOK;
                end else begin
                  current_state_out <= cur_state;
                  accepted          <= cfg.accept_mask[cur_state];
                  status            <= ST_UNKNOWN;
                  out_valid         <= 1'b1;
                end
              end
              KIND_WRITE: begin
                vld[waddr]        <= 1'b1;
                current_state_out <= cur_state;
                accepted          <= cfg.accept_mask[cur_state];
                status            <= ST_OK;
                out_valid         <= 1'b1;
              end
              KIND_RESTART: begin
                cur_state         <= cfg.start_state;
                current_state_out <= cfg.start_state;
                accepted          <= cfg.accept_mask[cfg.start_state];
                status            <= ST_OK;
                out_valid         <= 1'b1;
              end
              default: begin
                current_state_out <= cur_state;
                accepted          <= cfg.accept_mask[cur_state];
                status            <= ST_OK;
                out_valid         <= 1'b1;
              end
            endcase
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_LOOK: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
          if (rd_def) begin
            cur_state         <= rd_entry[STATE_W-1:0];
            current_state_out <= rd_entry[STATE_W-1:0];
            accepted          <= cfg.accept_mask[rd_entry[STATE_W-1:0]];
            status            <= ST_OK;
          end else begin
            current_state_out <= cur_state;
            accepted          <= cfg.accept_mask[cur_state];
            status            <= ST_UNDEF;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TDFA_ASSERT_IMPL(a_look_slot_free, state == S_LOOK, !out_valid, "result slot taken")
  `TDFA_ASSERT_NEXT(a_look_follows, do_look, state == S_LOOK, "read without lookup")
  `TDFA_ASSERT_NEXT(a_undef_holds, state == S_LOOK && !rd_def, $stable(cur_state), "state moved")

endmodule

// ===== tb/table_driven_dfa_recognizer_unit_tb.sv =====
`timescale 1ns / 1ps

module table_driven_dfa_recognizer_unit_tb;
  import tdfa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  symbol;
    logic [STATE_W-1:0] from_state;
    logic [IDX_W-1:0]   symbol_index;
    logic [STATE_W-1:0] target_state;
    logic               entry_defined;
  } dfa_beat_t;

  typedef struct packed {
    logic [STATE_W-1:0]  state;
    logic                acc;
    logic [STATUS_W-1:0] status;
  } dfa_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     kind = '0;
  logic [CHAR_W-1:0]     symbol = '0;
  logic [STATE_W-1:0]    from_state = '0;
  logic [IDX_W-1:0]      symbol_index = '0;
  logic [STATE_W-1:0]    target_state = '0;
  logic                  entry_defined = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATE_W-1:0]    current_state_out;
  logic                  accepted;
  logic [STATUS_W-1:0]   status;

  logic [STATE_W-1:0]    cfg_start = '0;
  logic [NUM_STATES-1:0] cfg_accept = '0;
  logic [CFG_DATA_W-1:0] cfg_chars = '0;
  logic [LEN_W-1:0]      cfg_len = 4'd1;
  logic [STATE_W-1:0]    cur_state = '0;
  logic                  tbl_def [NUM_STATES][NUM_SYMBOLS];
  logic [STATE_W-1:0]    tbl_tgt [NUM_STATES][NUM_SYMBOLS];

  dfa_result_t awaited_results[$];
  int          mismatches = 0;
  int          stall_count = 0;
  int          tx_idle_pct = 38;
  int          rx_idle_pct = 70;
  logic        rx_hold = 1'b0;

  table_driven_dfa_recognizer_unit dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .symbol            (symbol),
    .from_state        (from_state),
    .symbol_index      (symbol_index),
    .target_state      (target_state),
    .entry_defined     (entry_defined),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .current_state_out (current_state_out),
    .accepted          (accepted),
    .status            (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int alpha_span();
    return (cfg_len > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(cfg_len);
  endfunction

  function automatic dfa_result_t advance_automaton(input dfa_beat_t b);
    dfa_result_t r;
    int          idx;
    int          i;
    r.status = ST_OK;
    idx = -1;
    case (b.kind)
      KIND_STEP: begin
        for (i = alpha_span() - 1; i >= 0; i--)
          if (cfg_chars[8*i +: 8] == b.symbol) idx = i;
        if (idx < 0) r.status = ST_UNKNOWN;
        else if (!tbl_def[cur_state][idx]) r.status = ST_UNDEF;
        else cur_state = tbl_tgt[cur_state][idx];
      end
      KIND_WRITE: begin
        tbl_def[b.from_state][b.symbol_index] = b.entry_defined;
        tbl_tgt[b.from_state][b.symbol_index] = b.entry_defined ? b.target_state : '0;
      end
      KIND_RESTART: cur_state = cfg_start;
      default: ;
    endcase
    r.state = cur_state;
    r.acc = cfg_accept[cur_state];
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    out_ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : monitor
    dfa_result_t want;
    dfa_beat_t   seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("unexpected result state %0d acc %0b status %0d",
                                 current_state_out, accepted, status));
        end else begin
          want = awaited_results.pop_front();
          if (current_state_out !== want.state)
            note_failure($sformatf("state exp %0d got %0d", want.state, current_state_out));
          if (accepted !== want.acc)
            note_failure($sformatf("accepted exp %0b got %0b", want.acc, accepted));
          if (status !== want.status)
            note_failure($sformatf("status exp %0d got %0d", want.status, status));
        end
      end
      if (in_valid && in_ready) begin
        seen = '{kind, symbol, from_state, symbol_index, target_state, entry_defined};
        awaited_results.push_back(advance_automaton(seen));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_count = 0;
      else stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("FAIL table_driven_dfa_recognizer_unit");
        $finish;
      end
    end
  end

  task automatic send_beat(input dfa_beat_t b);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= b.kind;
    symbol        <= b.symbol;
    from_state    <= b.from_state;
    symbol_index  <= b.symbol_index;
    target_state  <= b.target_state;
    entry_defined <= b.entry_defined;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_START_STATE: cfg_start = data[STATE_W-1:0];
      REG_ACCEPT_MASK: cfg_accept = data[NUM_STATES-1:0];
      REG_ALPHA_CHARS: cfg_chars = data;
      REG_ALPHA_LEN:   cfg_len = data[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic hold_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  function automatic dfa_beat_t mk_beat(input logic [KIND_W-1:0] k,
                                        input logic [CHAR_W-1:0] sym,
                                        input logic [STATE_W-1:0] from,
                                        input logic [IDX_W-1:0] sidx,
                                        input logic [STATE_W-1:0] tgt,
                                        input logic def);
    dfa_beat_t b;
    b = '{k, sym, from, sidx, tgt, def};
    return b;
  endfunction

  function automatic dfa_beat_t random_beat();
    dfa_beat_t   b;
    logic [31:0] r;
    int          pick;
    int          span;
    r = $urandom;
    b.kind = r[1:0];
    b.symbol = r[9:2];
    b.from_state = r[13:10];
    b.symbol_index = r[16:14];
    b.target_state = r[20:17];
    b.entry_defined = r[21];
    pick = $urandom_range(99);
    span = alpha_span();
    if (pick < 80) begin
      b.kind = KIND_STEP;
      if (span > 0 && pick < 72) b.symbol = cfg_chars[8*$urandom_range(span - 1) +: 8];
    end else if (pick < 90) begin
      b.kind = KIND_WRITE;
      b.entry_defined = (pick < 88);
    end else if (pick < 97) begin
      b.kind = KIND_RESTART;
    end else begin
      b.kind = KIND_UNUSED;
    end
    return b;
  endfunction

  function automatic dfa_beat_t table_fill_beat();
    dfa_beat_t b;
    b = random_beat();
    b.kind = KIND_WRITE;
    b.symbol_index = 3'($urandom_range(alpha_span() - 1));
    b.entry_defined = ($urandom_range(9) != 0);
    return b;
  endfunction

  task automatic test_reset_state();
    send_beat(mk_beat(KIND_STEP, 8'h00, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_STEP, 8'hFF, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_UNUSED, 8'hFF, 4'hF, 3'h7, 4'hF, 1'b1));
    send_beat(mk_beat(KIND_RESTART, '0, '0, '0, '0, 1'b0));
  endtask

  task automatic test_table_walk();
    wait_idle();
    write_reg(REG_START_STATE, 64'd0);
    write_reg(REG_ACCEPT_MASK, 64'h8001);
    write_reg(REG_ALPHA_CHARS, 64'hFE7F_8001_AA55_FF00);
    write_reg(REG_ALPHA_LEN, 64'd8);
    send_beat(mk_beat(KIND_WRITE, '0, 4'd0, 3'd0, 4'd15, 1'b1));
    send_beat(mk_beat(KIND_WRITE, '0, 4'd15, 3'd7, 4'd0, 1'b1));
    send_beat(mk_beat(KIND_WRITE, '0, 4'd15, 3'd1, 4'd5, 1'b1));
    send_beat(mk_beat(KIND_STEP, 8'h00, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_STEP, 8'hFF, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_STEP, 8'h00, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_STEP, 8'h42, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_RESTART, '0, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_STEP, 8'h00, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_STEP, 8'hFE, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_WRITE, '0, 4'd0, 3'd0, 4'd9, 1'b0));
    send_beat(mk_beat(KIND_STEP, 8'h00, '0, '0, '0, 1'b0));
    wait_idle();
    write_reg(REG_START_STATE, 64'd15);
    send_beat(mk_beat(KIND_STEP, 8'hFF, '0, '0, '0, 1'b0));
    send_beat(mk_beat(KIND_RESTART, '0, '0, '0, '0, 1'b0));
  endtask

  task automatic test_alphabet_bounds();
    wait_idle();
    write_reg(REG_ALPHA_CHARS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ALPHA_LEN, 64'd15);
    send_beat(mk_beat(KIND_WRITE, '0, 4'd15, 3'd0, 4'd3, 1'b1));
    send_beat(mk_beat(KIND_STEP, 8'hFF, '0, '0, '0, 1'b0));
    wait_idle();
    write_reg(REG_ALPHA_LEN, 64'd0);
    send_beat(mk_beat(KIND_STEP, 8'hFF, '0, '0, '0, 1'b0));
    wait_idle();
    write_reg(REG_ACCEPT_MASK, 64'hFFFF);
    send_beat(mk_beat(KIND_RESTART, '0, '0, '0, '0, 1'b0));
  endtask

  task automatic test_random_traffic(input int n_items);
    int         i;
    logic [3:0] len;
    wait_idle();
    write_reg(REG_START_STATE, 64'($urandom_range(NUM_STATES - 1)));
    write_reg(REG_ACCEPT_MASK, 64'($urandom_range(16'hFFFF)));
    write_reg(REG_ALPHA_CHARS, {$urandom, $urandom});
    len = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 1));
    write_reg(REG_ALPHA_LEN, 64'(len));
    for (i = 0; i < 64; i++) send_beat(table_fill_beat());
    send_beat(mk_beat(KIND_RESTART, '0, '0, '0, '0, 1'b0));
    for (i = 0; i < n_items; i++) send_beat(random_beat());
  endtask

  task automatic test_backpressure();
    int i;
    int saved;
    saved = tx_idle_pct;
    tx_idle_pct = 0;
    // hold the receiver off so the input side backs up
    fork
      hold_receiver(300);
    join_none
    for (i = 0; i < 40; i++) send_beat(random_beat());
    tx_idle_pct = saved;
  endtask

  initial begin
    foreach (tbl_def[s, j]) begin
      tbl_def[s][j] = 1'b0;
      tbl_tgt[s][j] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_table_walk();
    test_alphabet_bounds();
    test_random_traffic(560);
    tx_idle_pct = 70;
    rx_idle_pct = 38;
    test_backpressure();
    test_random_traffic(560);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(560);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += awaited_results.size();
    if (mismatches == 0) begin
      $display("PASS table_driven_dfa_recognizer_unit");
    end else begin
      $display("FAIL table_driven_dfa_recognizer_unit");
    end
    $finish;
  end

endmodule
